[design/ordered_list_insert_remove_find_assert.svh]
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Short forms for the concurrent checks on the ordered list ports.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_REMOVE_FIND_ASSERT_SVH
`define ORDERED_LIST_INSERT_REMOVE_FIND_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OLIR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OLIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/olir_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered list package
// Beat types, action and status codes shared by the ordered list modules.
// ----------------------------------------------------------------------------
package olir_pkg;

  // Default number of entries the list can hold.
  localparam int DEF_CAPACITY = 64;

  // Fixed field widths.
  localparam int POS_W     = 7;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 7;

  // Action codes carried by an input beat.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2
  } action_t;

  // Status codes carried by a result beat.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Input beat.
  typedef struct packed {
    logic [1:0]              action;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic                 found;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [1:0]           status;
  } out_beat_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic                    srch;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } cell_op_t;

endpackage

[design/olir_cell.sv]
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one entry; shifts from its neighbours on insert and remove and
// compares its entry against a search value.
// ----------------------------------------------------------------------------
module olir_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  olir_pkg::cell_op_t               op,
  input  logic [CNT_W-1:0]                 cnt,
  input  logic signed [olir_pkg::VAL_W-1:0] left_entry,
  input  logic signed [olir_pkg::VAL_W-1:0] right_entry,
  output logic signed [olir_pkg::VAL_W-1:0] entry,
  output logic                             match
);
  import olir_pkg::*;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CMP_W-1:0] IDX_C = CMP_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_N = CNT_W'(IDX);

  logic signed [VAL_W-1:0] entry_r, entry_nxt;
  logic                    match_r, match_nxt;
  logic [CMP_W-1:0]        pos_c;

  assign pos_c = CMP_W'(op.position);

  // Entries after the insert point take the left neighbour's beat; entries
  // from the remove point onwards take the right neighbour's.
  always_comb begin
    entry_nxt = entry_r;
    if (op.ins) begin
      if (IDX_C > pos_c) begin
        entry_nxt = left_entry;
      end else if (IDX_C == pos_c) begin
        entry_nxt = op.value;
      end
    end else if (op.rem && (IDX_C >= pos_c)) begin
      entry_nxt = right_entry;
    end
  end

  // Only occupied cells may report a hit.
  assign match_nxt = op.srch && (IDX_N < cnt) && (entry_r == op.value);

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

[design/olir_reduce.sv]
// ----------------------------------------------------------------------------
// Ordered list hit reduction
// Registered OR tree that folds the per-cell hit flags into one found flag.
// ----------------------------------------------------------------------------
module olir_reduce #(
  parameter int N = 64
) (
  input  logic         clk,
  input  logic [N-1:0] match,
  output logic         found
);

  localparam int GRP   = 32;
  localparam int NGRP  = (N + GRP - 1) / GRP;
  localparam int TOT_W = NGRP * GRP;

  logic [TOT_W-1:0] padded;
  logic [NGRP-1:0]  grp_r, grp_nxt;

  assign padded = TOT_W'(match);

  // First level: one OR per group of cells.
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    assign grp_nxt[g] = |padded[g*GRP +: GRP];
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  // Second level: OR across the registered groups.
  assign found = |grp_r;

endmodule

[design/ordered_list_insert_remove_find.sv]
// ----------------------------------------------------------------------------
// Ordered list with insert, remove and find
// Bounded ordered sequence of signed 32-bit values kept in a chain of cells.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Beat
//  in_      input      in_valid / in_stall   action, value, position
//  out_     output     out_valid / out_stall found, entry_count, status
//
//  Between taking an item and taking the next, the block steps through these:
//  the cells update and register their hit flags, the OR tree registers the
//  group flags, the result register loads and the result beat is handed over.
//  A stalled result holds the block; a new beat is taken only once it leaves.
//  Reset clears the entry count; cell contents are undefined until written.
module ordered_list_insert_remove_find #(
  parameter int CAPACITY = olir_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  olir_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output olir_pkg::out_beat_t out_beat
);
  import olir_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_TREE,
    S_SHOW
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  status_t                 stat_r, stat_nxt, res_stat;
  out_beat_t               out_r, out_nxt;
  logic                    accept;
  logic                    do_ins, do_rem, do_srch;
  logic [CMP_W-1:0]        pos_c, cnt_c;
  cell_op_t                op;
  logic signed [VAL_W-1:0] ent [CAPACITY];
  logic [CAPACITY-1:0]     match_w;
  logic                    found;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign pos_c    = CMP_W'(in_beat.position);
  assign cnt_c    = CMP_W'(cnt_r);

  // Decode the action and check it against the current count.
  always_comb begin
    res_stat = ST_DONE;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_srch  = 1'b0;
    case (in_beat.action)
      ACT_INSERT: begin
        if (cnt_r == CAP_C) begin
          res_stat = ST_FULL;
        end else if (pos_c > cnt_c) begin
          res_stat = ST_RANGE;
        end else begin
          do_ins = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (cnt_r == '0) begin
          res_stat = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          res_stat = ST_RANGE;
        end else begin
          do_rem = 1'b1;
        end
      end
      ACT_SEARCH: begin
        do_srch = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Operation to the cells, count and status for the accepted beat.
  always_comb begin
    op.ins      = accept && do_ins;
    op.rem      = accept && do_rem;
    op.srch     = accept && do_srch;
    op.position = in_beat.position;
    op.value    = in_beat.value;
    cnt_nxt     = cnt_r;
    stat_nxt    = stat_r;
    if (accept) begin
      stat_nxt = res_stat;
      if (do_ins) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (do_rem) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  // The chain of cells; the ends see the new value and their own entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = in_beat.value;
    end else begin : g_mid_l
      assign left_w = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = ent[i];
    end else begin : g_mid_r
      assign right_w = ent[i+1];
    end
    olir_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .cnt         (cnt_r),
      .left_entry  (left_w),
      .right_entry (right_w),
      .entry       (ent[i]),
      .match       (match_w[i])
    );
  end

  olir_reduce #(
    .N (CAPACITY)
  ) u_reduce (
    .clk   (clk),
    .match (match_w),
    .found (found)
  );

  // Sequencer: accept, hit flags, group flags, result beat.
  always_comb begin
    state_nxt = state_r;
    out_nxt   = out_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_TREE;
      end
      S_TREE: begin
        state_nxt           = S_SHOW;
        out_nxt.found       = found;
        out_nxt.entry_count = CNT_OUT_W'(cnt_r);
        out_nxt.status      = stat_r;
      end
      S_SHOW: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      stat_r  <= ST_DONE;
      out_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      stat_r  <= stat_nxt;
      out_r   <= out_nxt;
    end
  end

  assign out_valid = (state_r == S_SHOW);
  assign out_beat  = out_r;

endmodule

[design/olir_checker.sv]
// ----------------------------------------------------------------------------
// Ordered list port checker
// Concurrent checks on the ordered list ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_remove_find_assert.svh"

module olir_checker #(
  parameter int CAPACITY = olir_pkg::DEF_CAPACITY
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input olir_pkg::out_beat_t out_beat
);
  import olir_pkg::*;

  // A stalled result beat stays and holds its value.
  `OLIR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat), "stalled result beat changed")

  // One item at a time: the input stalls right after a beat is taken.
  `OLIR_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "input taken while busy")

  // A refused insert reports a full list.
  `OLIR_ASSERT_SAME(a_full_cnt, out_valid && (out_beat.status == ST_FULL), out_beat.entry_count == CNT_OUT_W'(CAPACITY), "full status with wrong count")

  // A refused remove reports an empty list.
  `OLIR_ASSERT_SAME(a_empty_cnt, out_valid && (out_beat.status == ST_EMPTY), out_beat.entry_count == '0, "empty status with nonzero count")

  // Only a search can find, and a search always completes.
  `OLIR_ASSERT_SAME(a_found_ok, out_valid && out_beat.found, out_beat.status == ST_DONE, "found flag with failing status")

endmodule

bind ordered_list_insert_remove_find olir_checker #(.CAPACITY(CAPACITY)) u_olir_checker (.*);

[bench/ordered_list_insert_remove_find_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list insert/remove/find testbench
// Drives insert, remove, search and unused-action beats through the block with
// random idling on both channels. A behavioural copy of the list predicts each
// result beat, which is then checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_find_tb;
  import olir_pkg::*;

  localparam int          LIST_CAPACITY = DEF_CAPACITY;
  localparam int          CLK_HALF      = 4;
  localparam int          RANDOM_OPS    = 1700;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          QUIET_START   = 1500;
  localparam int          QUIET_END     = 3500;
  localparam int          IDLE_PCT      = 23;
  localparam int          DRAIN_CYCLES  = 16;
  localparam logic [1:0]  ACT_UNUSED    = 2'd3;
  localparam logic [POS_W-1:0] POS_TOP  = '1;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  // Stimulus and prediction stores.
  in_beat_t                pending_list_ops[$];
  out_beat_t               expected_list_results[$];
  logic signed [VAL_W-1:0] model_entries[$];
  int unsigned             shadow_count = 0;
  int unsigned             queued_ops   = 0;
  int unsigned             error_count  = 0;
  int unsigned             cycle_count  = 0;
  logic                    quiet;

  ordered_list_insert_remove_find #(
    .CAPACITY (LIST_CAPACITY)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always #(CLK_HALF) clk = ~clk;

  // Neither side idles inside the quiet window.
  assign quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

  // Apply one operation to the behavioural list and return the result beat.
  function automatic out_beat_t apply_list_op(in_beat_t beat);
    out_beat_t   res;
    int unsigned cnt;
    res = '0;
    cnt = model_entries.size();
    case (beat.action)
      ACT_INSERT: begin
        // A full list is refused before the position is looked at.
        if (cnt >= LIST_CAPACITY) res.status = ST_FULL;
        else if (beat.position > cnt) res.status = ST_RANGE;
        else model_entries.insert(int'(beat.position), beat.value);
      end
      ACT_REMOVE: begin
        if (cnt == 0) res.status = ST_EMPTY;
        else if (beat.position >= cnt) res.status = ST_RANGE;
        else model_entries.delete(int'(beat.position));
      end
      ACT_SEARCH: begin
        foreach (model_entries[i]) begin
          if (model_entries[i] == beat.value) res.found = 1'b1;
        end
      end
      default: ;
    endcase
    res.entry_count = CNT_OUT_W'(model_entries.size());
    return res;
  endfunction

  // Values lean on a small pool so that searches hit often.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned             roll;
    logic signed [VAL_W-1:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      v = $signed($urandom_range(0, 15)) - 32'sd8;
    end else if (roll < 50) begin
      case ($urandom_range(0, 3))
        0:       v = VAL_MAX;
        1:       v = VAL_MIN;
        2:       v = '0;
        default: v = '1;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Queue one beat and track the count it leaves behind for later shaping.
  task automatic queue_list_op(input logic [1:0] act, input logic signed [VAL_W-1:0] val,
                               input logic [POS_W-1:0] pos);
    in_beat_t beat;
    beat.action   = act;
    beat.value    = val;
    beat.position = pos;
    pending_list_ops.insert(pending_list_ops.size(), beat);
    queued_ops++;
    if (act == ACT_INSERT && shadow_count < LIST_CAPACITY && pos <= shadow_count)
      shadow_count++;
    else if (act == ACT_REMOVE && shadow_count > 0 && pos < shadow_count)
      shadow_count--;
  endtask

  // Random beat with the given insert and remove weights in percent.
  task automatic queue_random_op(input int unsigned ins_pct, input int unsigned rem_pct);
    int unsigned      roll;
    int unsigned      top;
    logic [1:0]       act;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) act = ACT_INSERT;
    else if (roll < ins_pct + rem_pct) act = ACT_REMOVE;
    else if (roll < 97) act = ACT_SEARCH;
    else act = ACT_UNUSED;
    // Highest legal position for this action.
    top = (act == ACT_INSERT) ? shadow_count : ((shadow_count > 0) ? shadow_count - 1 : 0);
    roll = $urandom_range(0, 99);
    if (roll < 12) pos = POS_W'($urandom_range(0, 127));
    else if (roll < 22) pos = '0;
    else if (roll < 32) pos = POS_W'(top);
    else pos = POS_W'($urandom_range(0, top));
    queue_list_op(act, pick_value(), pos);
  endtask

  // Stimulus: directed beats, a full drain, then shaped random sequences.
  initial begin
    int unsigned round_idx;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: remove refused before position, search misses, unused action.
    queue_list_op(ACT_REMOVE, 32'sd0, 7'd0);
    queue_list_op(ACT_REMOVE, VAL_MAX, POS_TOP);
    queue_list_op(ACT_SEARCH, 32'sd0, 7'd0);
    queue_list_op(ACT_UNUSED, 32'sd0, 7'd0);
    queue_list_op(ACT_INSERT, 32'sd5, 7'd1);
    // Build -1, 0, max, min using front, back and middle inserts.
    queue_list_op(ACT_INSERT, VAL_MAX, 7'd0);
    queue_list_op(ACT_INSERT, VAL_MIN, 7'd1);
    queue_list_op(ACT_INSERT, -32'sd1, 7'd0);
    queue_list_op(ACT_INSERT, 32'sd0, 7'd1);
    queue_list_op(ACT_INSERT, 32'sd7, POS_TOP);
    queue_list_op(ACT_INSERT, 32'sd7, 7'd5);
    queue_list_op(ACT_SEARCH, VAL_MAX, 7'd0);
    queue_list_op(ACT_SEARCH, VAL_MIN, POS_TOP);
    queue_list_op(ACT_SEARCH, 32'sd7, 7'd0);
    // Remove positions at and beyond the count, then unused action with all ones.
    queue_list_op(ACT_REMOVE, 32'sd0, 7'd4);
    queue_list_op(ACT_REMOVE, 32'sd0, POS_TOP);
    queue_list_op(ACT_UNUSED, '1, POS_TOP);
    // Remove back and front; removed values must no longer be found.
    queue_list_op(ACT_REMOVE, 32'sd0, 7'd3);
    queue_list_op(ACT_SEARCH, VAL_MIN, 7'd0);
    queue_list_op(ACT_REMOVE, 32'sd0, 7'd0);
    queue_list_op(ACT_SEARCH, -32'sd1, 7'd0);
    queue_list_op(ACT_REMOVE, 32'sd0, 7'd1);
    queue_list_op(ACT_REMOVE, 32'sd0, 7'd0);
    queue_list_op(ACT_SEARCH, 32'sd0, 7'd0);

    // Hold the sender until every directed result has come back.
    while (pending_list_ops.size() != 0 || in_valid || expected_list_results.size() != 0)
      @(posedge clk);

    // Rounds of fill to full, mixed traffic, drain to empty, mixed traffic.
    round_idx = 0;
    while (queued_ops < RANDOM_OPS + 24) begin
      case (round_idx % 4)
        0: begin
          while (shadow_count < LIST_CAPACITY) queue_random_op(88, 4);
          repeat (4) queue_random_op(100, 0);
        end
        2: begin
          while (shadow_count > 0) queue_random_op(4, 88);
          repeat (4) queue_random_op(0, 100);
        end
        default: repeat (40) queue_random_op(35, 30);
      endcase
      round_idx++;
    end

    // Wait for the last beat to be taken and its result to arrive.
    while (pending_list_ops.size() != 0 || in_valid || expected_list_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Driver: predict on acceptance, then present the next beat or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_beat  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_list_results.insert(expected_list_results.size(),
                                     apply_list_op(in_beat));
      end
      if (!in_valid || !in_stall) begin
        if (pending_list_ops.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_beat  <= pending_list_ops[0];
          pending_list_ops.delete(0);
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_list_results.size() == 0) begin
          $error("Result beat with no expectation waiting");
          error_count++;
        end else begin
          exp_beat = expected_list_results[0];
          expected_list_results.delete(0);
          if (out_beat.found !== exp_beat.found) begin
            $error("Field found: expected %0d, actual %0d", exp_beat.found, out_beat.found);
            error_count++;
          end
          if (out_beat.entry_count !== exp_beat.entry_count) begin
            $error("Field entry_count: expected %0d, actual %0d",
                   exp_beat.entry_count, out_beat.entry_count);
            error_count++;
          end
          if (out_beat.status !== exp_beat.status) begin
            $error("Field status: expected %0d, actual %0d", exp_beat.status, out_beat.status);
            error_count++;
          end
        end
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

[filelist.f]
+incdir+design
design/olir_pkg.sv
design/olir_cell.sv
design/olir_reduce.sv
design/ordered_list_insert_remove_find.sv
design/olir_checker.sv
bench/ordered_list_insert_remove_find_tb.sv
